/* hw/rtl/pss_pkg.sv */
// Shared types, constants and command codes for the positional sequence store.
package pss_pkg;

  // Store geometry
  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  // Port field widths
  localparam int CMD_BITS    = 3;
  localparam int POS_BITS    = 5;
  localparam int STATUS_BITS = 2;
  localparam int IN_VAL_BITS = 32;
  localparam int RD_BITS     = 32;
  localparam int COUNT_BITS  = 5;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  // Command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_READ      = 3'd6,
    CMD_UNUSED    = 3'd7
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    STAT_DONE = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_READ,
    S_RESP
  } state_t;

  // Completed command, handed from the sequencer to the output register
  typedef struct packed {
    logic    valid;
    status_t status;
    cnt_t    count;
    logic    is_read;
  } resp_t;

endpackage

/* hw/rtl/positional_sequence_store_core.sv */
// Top level of the positional sequence store: element RAM, sequencer and result register.
//
// Holds an ordered list of up to 16 signed 32-bit values in a single-port-pair RAM.
// Input channel (in_valid/in_ready) takes one command beat: insert front/back/at
// position, delete front/back/at position, or read at a 1-based position.
// Result channel (out_valid/out_ready) returns one beat per command with a status,
// the element count after the command and, for a good read, the element value.
// Each command is handled alone; in_ready is low while one is in flight.
// Inserts and deletes move one element at a time: a RAM read (S_SH_RD), then a write (S_SH_WR).
// An insert then writes the new value (S_PUT); at most 15 elements are moved per command.
// A read passes through S_READ, and a refused or ignored command goes straight to S_RESP.
// The held result register lets the next command be accepted in the cycle the
// previous result is taken. While out_ready is low the result holds and no new
// command is taken.
// Reset empties the store at once (count to zero); no clearing pass is needed.
module positional_sequence_store_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [pss_pkg::CMD_BITS-1:0]           in_command,
  input  logic signed [pss_pkg::IN_VAL_BITS-1:0] in_value,
  input  logic [pss_pkg::POS_BITS-1:0]           in_position,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pss_pkg::STATUS_BITS-1:0]        out_status,
  output logic [pss_pkg::COUNT_BITS-1:0]         out_element_count,
  output logic signed [pss_pkg::RD_BITS-1:0]     out_read_value
);

  logic            out_valid_r, out_valid_nxt;
  logic [pss_pkg::STATUS_BITS-1:0]   out_status_r, out_status_nxt;
  logic [pss_pkg::COUNT_BITS-1:0]    out_count_r, out_count_nxt;
  logic signed [pss_pkg::RD_BITS-1:0] out_rd_r, out_rd_nxt;

  logic            out_free;
  logic            ram_we;
  pss_pkg::idx_t   ram_waddr;
  pss_pkg::idx_t   ram_raddr;
  pss_pkg::value_t ram_wdata;
  pss_pkg::value_t ram_rdata;
  pss_pkg::resp_t  resp;

  assign out_free = !out_valid_r || out_ready;

  pss_ram #(
    .WIDTH (pss_pkg::VALUE_BITS),
    .DEPTH (pss_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pss_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_command  (in_command),
    .in_value    (in_value),
    .in_position (in_position),
    .out_free    (out_free),
    .in_ready    (in_ready),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .resp        (resp)
  );

  // Load a finished result, drop it once the receiver takes the beat
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_rd_nxt     = out_rd_r;
    if (resp.valid) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pss_pkg::STATUS_BITS'(resp.status);
      out_count_nxt  = pss_pkg::COUNT_BITS'(resp.count);
      out_rd_nxt     = resp.is_read ? pss_pkg::RD_BITS'(ram_rdata) : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_rd_r     <= out_rd_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;
  assign out_read_value    = out_rd_r;

endmodule

/* hw/rtl/pss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

/* hw/rtl/pss_seq.sv */
// Command decode and shift sequencer: one cursor moves elements one RAM access at a time.
module pss_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [pss_pkg::CMD_BITS-1:0]        in_command,
  input  logic signed [pss_pkg::IN_VAL_BITS-1:0] in_value,
  input  logic [pss_pkg::POS_BITS-1:0]        in_position,
  input  logic                                out_free,
  output logic                                in_ready,
  output logic                                ram_we,
  output pss_pkg::idx_t                       ram_waddr,
  output pss_pkg::value_t                     ram_wdata,
  output pss_pkg::idx_t                       ram_raddr,
  input  pss_pkg::value_t                     ram_rdata,
  output pss_pkg::resp_t                      resp
);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DEL,
    OP_READ
  } op_t;

  pss_pkg::state_t  state_r, state_nxt;
  pss_pkg::cnt_t    count_r, count_nxt;
  pss_pkg::idx_t    k_r, k_nxt;
  pss_pkg::idx_t    target_r, target_nxt;
  logic             up_r, up_nxt;
  logic             ins_r, ins_nxt;
  logic             is_read_r, is_read_nxt;
  pss_pkg::status_t status_r, status_nxt;
  pss_pkg::value_t  val_r, val_nxt;

  logic             accept;
  pss_pkg::cmd_t    cmd;
  logic [pss_pkg::CNT_BITS:0] cnt_ext;
  logic [pss_pkg::CNT_BITS:0] pos_ext;
  logic             pos_nz;
  logic             ins_pos_ok;
  logic             del_pos_ok;
  logic             full;
  logic             empty;
  pss_pkg::idx_t    pos_idx;
  pss_pkg::idx_t    last_idx;
  op_t              dec_op;
  pss_pkg::status_t dec_status;
  pss_pkg::idx_t    dec_idx;
  pss_pkg::idx_t    src;

  assign in_ready = (state_r == pss_pkg::S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign cmd      = pss_pkg::cmd_t'(in_command);

  // Range checks on the requested position against the current count
  assign cnt_ext    = {1'b0, count_r};
  assign pos_ext    = (pss_pkg::CNT_BITS + 1)'(in_position);
  assign pos_nz     = (in_position != '0);
  assign ins_pos_ok = pos_nz && (pos_ext <= cnt_ext + 1'b1);
  assign del_pos_ok = pos_nz && (pos_ext <= cnt_ext);
  assign full       = (count_r == pss_pkg::CNT_BITS'(pss_pkg::DEPTH));
  assign empty      = (count_r == '0);
  assign pos_idx    = pss_pkg::IDX_BITS'(in_position - 1'b1);
  assign last_idx   = pss_pkg::IDX_BITS'(count_r - 1'b1);

  // Decode the command into an operation, a start index and a status
  always_comb begin
    dec_op     = OP_NONE;
    dec_status = pss_pkg::STAT_BAD;
    dec_idx    = '0;
    unique case (cmd)
      pss_pkg::CMD_INS_FRONT, pss_pkg::CMD_INS_BACK, pss_pkg::CMD_INS_POS: begin
        if (cmd == pss_pkg::CMD_INS_BACK) begin
          dec_idx = pss_pkg::IDX_BITS'(count_r);
        end else if (cmd == pss_pkg::CMD_INS_POS) begin
          dec_idx = pos_idx;
        end
        if (cmd == pss_pkg::CMD_INS_POS && !ins_pos_ok) begin
          dec_status = pss_pkg::STAT_BAD;
        end else if (full) begin
          dec_status = pss_pkg::STAT_FULL;
        end else begin
          dec_status = pss_pkg::STAT_DONE;
          dec_op     = OP_INS;
        end
      end
      pss_pkg::CMD_DEL_FRONT, pss_pkg::CMD_DEL_BACK, pss_pkg::CMD_DEL_POS: begin
        if (cmd == pss_pkg::CMD_DEL_BACK) begin
          dec_idx = last_idx;
        end else if (cmd == pss_pkg::CMD_DEL_POS) begin
          dec_idx = pos_idx;
        end
        if (empty || (cmd == pss_pkg::CMD_DEL_POS && !del_pos_ok)) begin
          dec_status = pss_pkg::STAT_BAD;
        end else begin
          dec_status = pss_pkg::STAT_DONE;
          dec_op     = OP_DEL;
        end
      end
      pss_pkg::CMD_READ: begin
        dec_idx = pos_idx;
        if (del_pos_ok) begin
          dec_status = pss_pkg::STAT_DONE;
          dec_op     = OP_READ;
        end
      end
      default: begin
        dec_status = pss_pkg::STAT_BAD;
      end
    endcase
  end

  // Shared cursor step: one neighbor toward the gap
  assign src = up_r ? k_r + 1'b1 : k_r - 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pss_pkg::S_IDLE: begin
        if (accept) begin
          unique case (dec_op)
            OP_INS: begin
              state_nxt = (pss_pkg::IDX_BITS'(count_r) == dec_idx) ? pss_pkg::S_PUT
                                                                   : pss_pkg::S_SH_RD;
            end
            OP_DEL: begin
              state_nxt = (dec_idx == last_idx) ? pss_pkg::S_RESP : pss_pkg::S_SH_RD;
            end
            OP_READ: state_nxt = pss_pkg::S_READ;
            default: state_nxt = pss_pkg::S_RESP;
          endcase
        end
      end
      pss_pkg::S_SH_RD: state_nxt = pss_pkg::S_SH_WR;
      pss_pkg::S_SH_WR: begin
        if (src == target_r) begin
          state_nxt = ins_r ? pss_pkg::S_PUT : pss_pkg::S_RESP;
        end else begin
          state_nxt = pss_pkg::S_SH_RD;
        end
      end
      pss_pkg::S_PUT:  state_nxt = pss_pkg::S_RESP;
      pss_pkg::S_READ: state_nxt = pss_pkg::S_RESP;
      pss_pkg::S_RESP: state_nxt = pss_pkg::S_IDLE;
      default:         state_nxt = pss_pkg::S_IDLE;
    endcase
  end

  // Outputs: RAM port control and the result beat
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = k_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = src;
    resp.valid    = 1'b0;
    resp.status   = status_r;
    resp.count    = count_r;
    resp.is_read  = is_read_r;
    unique case (state_r)
      pss_pkg::S_SH_WR: begin
        ram_we = 1'b1;
      end
      pss_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = target_r;
        ram_wdata = val_r;
      end
      pss_pkg::S_READ: begin
        ram_raddr = k_r;
      end
      pss_pkg::S_RESP: begin
        resp.valid = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Datapath registers: cursor, target, count and the held command
  always_comb begin
    k_nxt       = k_r;
    target_nxt  = target_r;
    up_nxt      = up_r;
    ins_nxt     = ins_r;
    is_read_nxt = is_read_r;
    status_nxt  = status_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    if (accept) begin
      status_nxt  = dec_status;
      is_read_nxt = (dec_op == OP_READ);
      ins_nxt     = (dec_op == OP_INS);
      val_nxt     = pss_pkg::VALUE_BITS'(in_value);
      unique case (dec_op)
        OP_INS: begin
          k_nxt      = pss_pkg::IDX_BITS'(count_r);
          target_nxt = dec_idx;
          up_nxt     = 1'b0;
          count_nxt  = count_r + 1'b1;
        end
        OP_DEL: begin
          k_nxt      = dec_idx;
          target_nxt = last_idx;
          up_nxt     = 1'b1;
          count_nxt  = count_r - 1'b1;
        end
        OP_READ: begin
          k_nxt = dec_idx;
        end
        default: begin
          k_nxt = k_r;
        end
      endcase
    end else if (state_r == pss_pkg::S_SH_WR) begin
      k_nxt = src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pss_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    target_r  <= target_nxt;
    up_r      <= up_nxt;
    ins_r     <= ins_nxt;
    is_read_r <= is_read_nxt;
    status_r  <= status_nxt;
    val_r     <= val_nxt;
  end

endmodule

/* sim/pss_result_checker.sv */
// Result checker for the positional sequence store: predicts every command beat and compares.
`timescale 1ns / 1ps

module pss_result_checker
  import pss_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [CMD_BITS-1:0]           in_command,
  input  logic signed [IN_VAL_BITS-1:0] in_value,
  input  logic [POS_BITS-1:0]           in_position,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [STATUS_BITS-1:0]        out_status,
  input  logic [COUNT_BITS-1:0]         out_element_count,
  input  logic signed [RD_BITS-1:0]     out_read_value,
  output int unsigned                   mismatches,
  output int unsigned                   outstanding
);

  typedef struct packed {
    status_t               status;
    logic [COUNT_BITS-1:0] count;
    logic [RD_BITS-1:0]    read_value;
  } store_result_t;

  // Shadow copy of the ordered list
  logic [VALUE_BITS-1:0] held_vals [DEPTH];
  int                    held_len;

  store_result_t awaited_results[$];
  int unsigned   result_beats;

  // Apply one command to the shadow list and return the result it should produce
  function automatic store_result_t predict_store_result(cmd_t cmd,
                                                         logic [IN_VAL_BITS-1:0] val,
                                                         logic [POS_BITS-1:0] pos);
    store_result_t res;
    int            slot;
    int            k;
    bit            apply;
    res   = '{status: STAT_DONE, count: '0, read_value: '0};
    apply = 1'b1;
    slot  = 0;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        if (cmd == CMD_INS_BACK) begin
          slot = held_len;
        end else if (cmd == CMD_INS_POS) begin
          if (pos == 0 || int'(pos) > held_len + 1) begin
            res.status = STAT_BAD;
            apply      = 1'b0;
          end else begin
            slot = int'(pos) - 1;
          end
        end
        // position is judged before fullness
        if (apply && held_len >= DEPTH) begin
          res.status = STAT_FULL;
          apply      = 1'b0;
        end
        // open a gap and shift later elements back
        if (apply) begin
          for (k = held_len; k > slot; k--) held_vals[k] = held_vals[k-1];
          held_vals[slot] = val;
          held_len++;
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
        if (held_len == 0) begin
          res.status = STAT_BAD;
          apply      = 1'b0;
        end else if (cmd == CMD_DEL_BACK) begin
          slot = held_len - 1;
        end else if (cmd == CMD_DEL_POS) begin
          if (pos == 0 || int'(pos) > held_len) begin
            res.status = STAT_BAD;
            apply      = 1'b0;
          end else begin
            slot = int'(pos) - 1;
          end
        end
        // close the gap and shift later elements forward
        if (apply) begin
          for (k = slot; k + 1 < held_len; k++) held_vals[k] = held_vals[k+1];
          held_len--;
        end
      end
      CMD_READ: begin
        if (pos == 0 || int'(pos) > held_len) res.status = STAT_BAD;
        else res.read_value = held_vals[int'(pos) - 1][RD_BITS-1:0];
      end
      default: res.status = STAT_BAD;
    endcase
    res.count = held_len[COUNT_BITS-1:0];
    return res;
  endfunction

  task automatic note_mismatch(string what, store_result_t exp, store_result_t got);
    if (mismatches < 10)
      $display({"%0t ns: result beat %0d %s: expected status %0d count %0d value %0d,",
                " got status %0d count %0d value %0d"},
               $time, result_beats, what, exp.status, exp.count, $signed(exp.read_value),
               got.status, got.count, $signed(got.read_value));
    mismatches++;
  endtask

  always @(posedge clk) begin
    store_result_t got;
    store_result_t exp;
    if (!rst_n) begin
      held_len = 0;
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      // check the result beat against the oldest prediction
      if (out_valid && out_ready) begin
        got.status     = status_t'(out_status);
        got.count      = out_element_count;
        got.read_value = out_read_value;
        if (awaited_results.size() == 0) begin
          note_mismatch("with no command pending", '0, got);
        end else begin
          exp = awaited_results.pop_front();
          if (got.status !== exp.status || got.count !== exp.count ||
              got.read_value !== exp.read_value)
            note_mismatch("mismatch", exp, got);
        end
        result_beats++;
      end
      // predict the command beat
      if (in_valid && in_ready)
        awaited_results.push_back(predict_store_result(cmd_t'(in_command), in_value,
                                                       in_position));
      outstanding <= awaited_results.size();
    end
  end

endmodule

/* sim/positional_sequence_store_core_tb.sv */
// Testbench top for the positional sequence store: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module positional_sequence_store_core_tb;
  import pss_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic [CMD_BITS-1:0]           in_command  = '0;
  logic signed [IN_VAL_BITS-1:0] in_value    = '0;
  logic [POS_BITS-1:0]           in_position = '0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic [STATUS_BITS-1:0]        out_status;
  logic [COUNT_BITS-1:0]         out_element_count;
  logic signed [RD_BITS-1:0]     out_read_value;
  int unsigned                   mismatches;
  int unsigned                   outstanding;

  // Stimulus steering: rough list length and how strongly to favor inserts
  int          fill_est  = 0;
  int unsigned grow_pct  = 75;
  logic        hold_req  = 1'b0;

  positional_sequence_store_core i_dut (.*);

  pss_result_checker i_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: cycle through ready patterns, with one long hold-off on request
  int unsigned rx_tick    = 0;
  int unsigned hold_count = 0;
  logic        hold_done  = 1'b0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_req && !hold_done) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      case ((rx_tick / 256) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rx_tick % 7) < 3);
      endcase
    end
  end

  // Keep the length estimate in step so positions land mostly in range
  function automatic void steer_length(cmd_t c, int p);
    case (c)
      CMD_INS_FRONT, CMD_INS_BACK: if (fill_est < DEPTH) fill_est++;
      CMD_INS_POS: if (p >= 1 && p <= fill_est + 1 && fill_est < DEPTH) fill_est++;
      CMD_DEL_FRONT, CMD_DEL_BACK: if (fill_est > 0) fill_est--;
      CMD_DEL_POS: if (p >= 1 && p <= fill_est) fill_est--;
      default: ;
    endcase
  endfunction

  // Offer one command beat and hold it until accepted
  task automatic send_command(cmd_t c, logic [IN_VAL_BITS-1:0] v, logic [POS_BITS-1:0] p);
    in_valid    <= 1'b1;
    in_command  <= c;
    in_value    <= v;
    in_position <= p;
    do @(posedge clk); while (!in_ready);
    steer_length(c, int'(p));
  endtask

  task automatic idle_for(int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_command();
    cmd_t                   c;
    logic [IN_VAL_BITS-1:0] v;
    logic [POS_BITS-1:0]    p;
    int unsigned            pick;
    pick = $urandom_range(0, 99);
    // mostly full-range values, sometimes the signed extremes or small ones
    case ($urandom_range(0, 9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = $urandom_range(0, 15);
      default: v = $urandom;
    endcase
    if (pick < 5) begin
      // noise: any code, any position
      c = cmd_t'($urandom_range(0, 7));
      p = POS_BITS'($urandom_range(0, 31));
    end else begin
      if (pick < 25)
        c = CMD_READ;
      else if ($urandom_range(0, 99) < grow_pct)
        c = cmd_t'($urandom_range(CMD_INS_FRONT, CMD_INS_POS));
      else
        c = cmd_t'($urandom_range(CMD_DEL_FRONT, CMD_DEL_POS));
      if ($urandom_range(0, 9) == 0)
        p = POS_BITS'($urandom_range(0, 31));
      else if (c == CMD_INS_POS)
        p = POS_BITS'($urandom_range(1, fill_est + 1));
      else
        p = POS_BITS'($urandom_range(fill_est == 0 ? 0 : 1, fill_est));
    end
    send_command(c, v, p);
    // swing between filling and emptying the list
    if (fill_est >= DEPTH) grow_pct = 25;
    else if (fill_est == 0) grow_pct = 75;
  endtask

  initial begin
    int unsigned item_no;
    int unsigned burst_left;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: every delete and read is ignored, unused code and out-of-range inserts too
    send_command(CMD_READ, 32'd0, 5'd1);
    send_command(CMD_DEL_FRONT, 32'd0, 5'd0);
    send_command(CMD_DEL_BACK, 32'd0, 5'd0);
    send_command(CMD_DEL_POS, 32'd0, 5'd1);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31);
    send_command(CMD_INS_POS, 32'd1, 5'd0);
    send_command(CMD_INS_POS, 32'd1, 5'd2);
    // build a short list through every insert kind
    send_command(CMD_INS_POS, 32'h8000_0000, 5'd1);
    send_command(CMD_INS_FRONT, 32'h7FFF_FFFF, 5'd0);
    send_command(CMD_INS_BACK, 32'hFFFF_FFFF, 5'd0);
    send_command(CMD_INS_POS, 32'd0, 5'd4);
    send_command(CMD_INS_POS, 32'h5A5A_A5A5, 5'd2);
    // reads at both ends and out of range
    send_command(CMD_READ, 32'd0, 5'd1);
    send_command(CMD_READ, 32'd0, 5'd5);
    send_command(CMD_READ, 32'd0, 5'd0);
    send_command(CMD_READ, 32'd0, 5'd6);
    send_command(CMD_READ, 32'd0, 5'd31);
    // deletes at last, first and middle positions, then bad ones, then front and back
    send_command(CMD_DEL_POS, 32'd0, 5'd5);
    send_command(CMD_DEL_POS, 32'd0, 5'd1);
    send_command(CMD_DEL_POS, 32'd0, 5'd2);
    send_command(CMD_DEL_POS, 32'd0, 5'd0);
    send_command(CMD_DEL_POS, 32'd0, 5'd3);
    send_command(CMD_DEL_FRONT, 32'd0, 5'd0);
    send_command(CMD_DEL_BACK, 32'd0, 5'd0);
    drain_results();

    // random traffic in bursts, with a long receiver hold-off and one full drain
    for (item_no = 0; item_no < RANDOM_ITEMS; item_no++) begin
      if (item_no == 400) hold_req <= 1'b1;
      if (item_no == 700) drain_results();
      send_random_command();
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 12));
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
